FILE: src/srt_pkg.sv
// Package for the sparse block reference-count table.
// Types, codes and constants shared by srt_table, srt_exec and the top level.
// No dependencies.
`default_nettype none

package srt_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned BlockWidth   = 32;
  localparam int unsigned CountWidth   = 32;

  localparam logic [CountWidth-1:0] CountMax  = '1;
  localparam logic [CountWidth-1:0] CountNew  = CountWidth'(2);
  localparam logic [CountWidth-1:0] CountOne  = CountWidth'(1);
  localparam logic [CountWidth-1:0] CountZero = '0;

  typedef enum logic [1:0] {
    CmdInc   = 2'd0,
    CmdDec   = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNull     = 2'd1,
    StOverflow = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [BlockWidth-1:0] block;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  freed;
    logic [CountWidth-1:0] count;
  } out_t;

  // result of the associative lookup
  typedef struct packed {
    logic                  hit;
    logic                  full;
    logic [CountWidth-1:0] hit_count;
  } lookup_t;

  // table update for one transfer; the slot travels as a one-hot vector
  typedef struct packed {
    logic                  ins;
    logic                  set_cnt;
    logic                  clr;
    logic [BlockWidth-1:0] block;
    logic [CountWidth-1:0] cnt;
  } upd_t;

endpackage

`default_nettype wire

FILE: src/srt_table.sv
// Associative entry storage: valid bits, block tags and counts in flops.
// Parallel tag compare, lowest-free-slot pick and one-hot update.
// Depends on srt_pkg.
`default_nettype none

module srt_table import srt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntries
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [BlockWidth-1:0]    blk_i,
  output lookup_t                       lk_o,
  output logic      [TABLE_ENTRIES-1:0] hit_oh_o,
  output logic      [TABLE_ENTRIES-1:0] free_oh_o,
  input  wire upd_t                     upd_i,
  input  wire logic [TABLE_ENTRIES-1:0] upd_oh_i
);

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [BlockWidth-1:0]    block_q [TABLE_ENTRIES];
  logic [CountWidth-1:0]    count_q [TABLE_ENTRIES];
  logic [CountWidth-1:0]    hit_cnt;

  // a block sits in at most one valid slot, so the hit vector is one-hot or zero
  always_comb begin
    hit_cnt = '0;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      hit_oh_o[i] = valid_q[i] && (block_q[i] == blk_i);
      hit_cnt     = hit_cnt | (hit_oh_o[i] ? count_q[i] : CountZero);
    end
  end

  // lowest clear bit of the valid vector
  assign free_oh_o = ~valid_q & (valid_q + TABLE_ENTRIES'(1));

  assign lk_o.hit       = |hit_oh_o;
  assign lk_o.full      = &valid_q;
  assign lk_o.hit_count = hit_cnt;

  always_comb begin
    valid_d = valid_q;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      if (upd_oh_i[i] && upd_i.ins) begin
        valid_d[i] = 1'b1;
      end else if (upd_oh_i[i] && upd_i.clr) begin
        valid_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      if (upd_oh_i[i] && upd_i.ins) begin
        block_q[i] <= upd_i.block;
      end
      if (upd_oh_i[i] && (upd_i.ins || upd_i.set_cnt)) begin
        count_q[i] <= upd_i.cnt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/srt_exec.sv
// Command decode: turns one item plus the lookup result into a result item
// and a table update. Purely combinational. Depends on srt_pkg.
`default_nettype none

module srt_exec import srt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntries
) (
  input  wire logic                     go_i,
  input  wire in_t                      item_i,
  input  wire lookup_t                  lk_i,
  input  wire logic [TABLE_ENTRIES-1:0] hit_oh_i,
  input  wire logic [TABLE_ENTRIES-1:0] free_oh_i,
  output out_t                          res_o,
  output upd_t                          upd_o,
  output logic      [TABLE_ENTRIES-1:0] upd_oh_o
);

  logic [CountWidth-1:0] cnt_inc, cnt_dec;
  logic                  ins, set_cnt, clr;

  assign cnt_inc = lk_i.hit_count + CountOne;
  assign cnt_dec = lk_i.hit_count - CountOne;

  always_comb begin
    res_o.status = StOk;
    res_o.freed  = 1'b0;
    res_o.count  = CountZero;
    ins          = 1'b0;
    set_cnt      = 1'b0;
    clr          = 1'b0;
    upd_oh_o     = hit_oh_i;
    if (item_i.block == '0) begin
      res_o.status = StNull;
    end else begin
      unique case (cmd_e'(item_i.cmd))
        CmdInc: begin
          if (lk_i.hit) begin
            if (lk_i.hit_count == CountMax) begin
              res_o.status = StOverflow;
            end else begin
              set_cnt     = 1'b1;
              res_o.count = cnt_inc;
            end
          end else if (lk_i.full) begin
            res_o.status = StFull;
          end else begin
            ins         = 1'b1;
            upd_oh_o    = free_oh_i;
            res_o.count = CountNew;
          end
        end
        CmdDec: begin
          if (!lk_i.hit) begin
            res_o.freed = 1'b1;
          end else if (lk_i.hit_count <= CountOne) begin
            clr         = 1'b1;
            res_o.freed = 1'b1;
          end else begin
            // dropping to one removes the entry; the implicit count takes over
            clr         = (cnt_dec == CountOne);
            set_cnt     = (cnt_dec != CountOne);
            res_o.count = cnt_dec;
          end
        end
        default: begin
          res_o.count = lk_i.hit ? lk_i.hit_count : CountOne;
        end
      endcase
    end
  end

  assign upd_o.ins     = go_i && ins;
  assign upd_o.set_cnt = go_i && set_cnt;
  assign upd_o.clr     = go_i && clr;
  assign upd_o.block   = item_i.block;
  assign upd_o.cnt     = ins ? CountNew : res_o.count;

endmodule

`default_nettype wire

FILE: src/sparse_block_refcount_table_top.sv
// Top level of the sparse block reference-count table.
// Input register, srt_table lookup/storage, srt_exec decode, result register.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries in_data_i (cmd, block).
//   Output channel out_valid_o/out_ready_i carries out_data_o
//   (status, freed, count). Every input transfer yields exactly one result.
//   Path: each item passes through the input register, then the result
//   register. Throughput: one item per cycle unless the output stalls; the
//   table lookup, decode and entry update all happen in the cycle an item
//   moves from the input register into the result register, so the next
//   item already sees the updated table.
//   Stall: while out_ready_i is low the result holds, one more item can
//   still be taken into the input register, then in_ready_o drops.
//   Reset: all entries become invalid at once (every block back to its
//   implicit count of one); no clearing pass, the block is ready right after
//   reset is released.
`default_nettype none

module sparse_block_refcount_table_top import srt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntries
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic                     s1_valid_q;
  in_t                      s1_q;
  logic                     out_valid_q;
  out_t                     out_q;
  logic                     s1_adv;
  lookup_t                  lk;
  logic [TABLE_ENTRIES-1:0] hit_oh, free_oh, upd_oh;
  upd_t                     upd;
  out_t                     res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  srt_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .blk_i    (s1_q.block),
    .lk_o     (lk),
    .hit_oh_o (hit_oh),
    .free_oh_o(free_oh),
    .upd_i    (upd),
    .upd_oh_i (upd_oh)
  );

  srt_exec #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_exec (
    .go_i     (s1_adv),
    .item_i   (s1_q),
    .lk_i     (lk),
    .hit_oh_i (hit_oh),
    .free_oh_i(free_oh),
    .res_o    (res),
    .upd_o    (upd),
    .upd_oh_o (upd_oh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a block never occupies two slots
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(hit_oh))
    else $error("block matched in more than one slot");

  // inserts only go to a free slot
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.ins |-> (!lk.full && !lk.hit && $onehot(upd_oh)))
    else $error("insert without a free slot");

  // a freed block reports no count and no error
  a_freed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.freed) |->
      (out_data_o.count == CountZero && out_data_o.status == StOk))
    else $error("freed result with count or error");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for sparse_block_refcount_table_top.
// Predicts every result with its own copy of the count table; depends only on srt_pkg
// and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  // unused command code, handled by the block as a query
  localparam logic [1:0] CmdSpare = 2'd3;

  localparam int HoldCycles    = 60;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 10;
  localparam int PoolSize      = 96;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // predicted table contents
  logic                  tbl_valid [TableEntries] = '{default: 1'b0};
  logic [BlockWidth-1:0] tbl_block [TableEntries];
  logic [CountWidth-1:0] tbl_count [TableEntries];

  out_t refcount_expected [$];
  out_t want;
  int   mismatch_count = 0;
  int   result_index = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_pending = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  logic [BlockWidth-1:0] block_pool [PoolSize];

  sparse_block_refcount_table_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the predicted table and returns its result.
  // A count at its maximum cannot be reached through the ports in a run of this length.
  function automatic out_t predict_refcount(in_t item);
    out_t r;
    int hit;
    int vacant;
    logic [CountWidth-1:0] c;
    r.status = StOk;
    r.freed  = 1'b0;
    r.count  = CountZero;
    hit = -1;
    vacant = -1;
    if (item.block == '0) begin
      r.status = StNull;
      return r;
    end
    for (int i = 0; i < TableEntries; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_block[i] == item.block) hit = i;
      if (vacant < 0 && !tbl_valid[i]) vacant = i;
    end
    case (item.cmd)
      CmdInc: begin
        if (hit >= 0) begin
          if (tbl_count[hit] == CountMax) begin
            r.status = StOverflow;
          end else begin
            tbl_count[hit] = tbl_count[hit] + CountOne;
            r.count = tbl_count[hit];
          end
        end else if (vacant < 0) begin
          r.status = StFull;
        end else begin
          tbl_valid[vacant] = 1'b1;
          tbl_block[vacant] = item.block;
          tbl_count[vacant] = CountNew;
          r.count = CountNew;
        end
      end
      CmdDec: begin
        if (hit < 0) begin
          r.freed = 1'b1;
        end else if (tbl_count[hit] <= CountOne) begin
          tbl_valid[hit] = 1'b0;
          r.freed = 1'b1;
        end else begin
          c = tbl_count[hit] - CountOne;
          if (c == CountOne) tbl_valid[hit] = 1'b0;
          else tbl_count[hit] = c;
          r.count = c;
        end
      end
      default: begin
        r.count = (hit >= 0) ? tbl_count[hit] : CountOne;
      end
    endcase
    return r;
  endfunction

  // Offers one command, holds it until the transfer, then records the prediction.
  task automatic send_cmd(input logic [1:0] cmd, input logic [BlockWidth-1:0] blk);
    in_t item;
    item.cmd   = cmd;
    item.block = blk;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    refcount_expected.push_back(predict_refcount(item));
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_pending) begin
      hold_left = HoldCycles;
      hold_pending = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (refcount_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("ERROR: unexpected result %0d: status %0d freed %0d count %0h",
                   result_index, out_data_o.status, out_data_o.freed, out_data_o.count);
      end else begin
        want = refcount_expected.pop_front();
        if (out_data_o.status !== want.status || out_data_o.freed !== want.freed ||
            out_data_o.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("ERROR: result %0d: expected status %0d freed %0d count %0h,",
                     result_index, want.status, want.freed, want.count,
                     " got status %0d freed %0d count %0h",
                     out_data_o.status, out_data_o.freed, out_data_o.count);
        end
      end
      result_index++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // null block, absent blocks, count walk, extreme block numbers, spare command
  task automatic test_directed_cases();
    logic [BlockWidth-1:0] bmax;
    logic [BlockWidth-1:0] bone;
    logic [BlockWidth-1:0] bhigh;
    bmax  = '1;
    bone  = BlockWidth'(1);
    bhigh = {1'b1, {(BlockWidth-1){1'b0}}};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cmd(CmdInc, '0);
    send_cmd(CmdDec, '0);
    send_cmd(CmdQuery, '0);
    send_cmd(CmdSpare, '0);
    send_cmd(CmdQuery, bmax);
    send_cmd(CmdDec, bmax);
    send_cmd(CmdInc, bmax);
    send_cmd(CmdInc, bmax);
    send_cmd(CmdQuery, bmax);
    send_cmd(CmdSpare, bmax);
    send_cmd(CmdInc, bone);
    send_cmd(CmdDec, bmax);
    send_cmd(CmdDec, bmax);
    send_cmd(CmdQuery, bmax);
    // slot 0 is free again; the new entry must land there
    send_cmd(CmdInc, bhigh);
    send_cmd(CmdDec, bone);
    send_cmd(CmdDec, bone);
    send_cmd(CmdInc, 32'h5555_5555);
    send_cmd(CmdInc, 32'hAAAA_AAAA);
    send_cmd(CmdSpare, 32'hAAAA_AAAA);
    send_cmd(CmdDec, 32'h5555_5555);
    send_cmd(CmdDec, 32'hAAAA_AAAA);
    send_cmd(CmdDec, bhigh);
  endtask

  // fill all slots, insert into a full table, free one slot and refill it
  task automatic test_table_full();
    logic [BlockWidth-1:0] fill [TableEntries+1];
    logic [BlockWidth-1:0] base;
    int k;
    int j;
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    base = $urandom() | 32'h0000_0100;
    for (int i = 0; i <= TableEntries; i++) fill[i] = base ^ i;
    for (int i = 0; i < TableEntries; i++) send_cmd(CmdInc, fill[i]);
    send_cmd(CmdInc, fill[TableEntries]);
    send_cmd(CmdQuery, fill[TableEntries]);
    k = $urandom_range(TableEntries-1);
    j = (k + 1 + $urandom_range(TableEntries-3)) % TableEntries;
    send_cmd(CmdInc, fill[k]);
    send_cmd(CmdDec, fill[j]);
    send_cmd(CmdInc, fill[TableEntries]);
    send_cmd(CmdInc, '0);
    send_cmd(CmdInc, ~fill[0]);
    for (int i = 0; i <= TableEntries; i++) send_cmd(CmdDec, fill[i]);
  endtask

  // random mix over a pool of live blocks, plus null and stray blocks
  task automatic test_random_traffic(input int n, input int pool_n, input int inc_pct,
                                     input int dec_pct, input int idle_pct,
                                     input int stall_pct);
    logic [1:0] cmd;
    logic [BlockWidth-1:0] blk;
    int r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < pool_n; i++) begin
      block_pool[i] = $urandom();
      if (block_pool[i] == '0) block_pool[i] = BlockWidth'(i + 1);
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < inc_pct) cmd = CmdInc;
      else if (r < inc_pct + dec_pct) cmd = CmdDec;
      else if (r < 96) cmd = CmdQuery;
      else cmd = CmdSpare;
      r = $urandom_range(99);
      if (r < 6) blk = '0;
      else if (r < 12) blk = $urandom();
      else blk = block_pool[$urandom_range(pool_n-1)];
      send_cmd(cmd, blk);
    end
  endtask

  // long receiver hold-off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_pending = 1'b1;
    for (int i = 0; i < 40; i++)
      send_cmd(logic'($urandom_range(1)) ? CmdInc : CmdQuery,
               block_pool[$urandom_range(PoolSize-1)]);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_table_full();
    test_random_traffic(300, 16, 45, 35, 0, 0);
    test_random_traffic(300, 96, 55, 25, 56, 0);
    test_random_traffic(300, 40, 40, 40, 0, 56);
    test_random_traffic(280, 96, 30, 50, 37, 37);
    test_backpressure();
    in_valid_i <= 1'b0;
    while (refcount_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
